@@ rtl/cbf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_pkg - shared types and constants
// Hash constants, state encodings and the probe word passed front to back.
// ----------------------------------------------------------------------------
package cbf_pkg;

	localparam int MAX_ADDR_BITS = 24;
	localparam int MAX_PROBES    = 16;
	localparam int SEED_W        = 10;
	localparam logic [SEED_W-1:0] SEED_STEP = 10'd47;

	localparam logic [63:0] MUL_C1  = 64'h87c37b91114253d5;
	localparam logic [63:0] MUL_C2  = 64'h4cf5ad432745937f;
	localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] KEY_LEN = 64'd8;

	localparam logic REG_PROBE_COUNT = 1'b0;
	localparam logic REG_TABLE_BITS  = 1'b1;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [3:0] {
		FS_IDLE, FS_K1A, FS_K1B, FS_PREP, FS_HA1, FS_HA2, FS_HB1, FS_HB2, FS_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		BS_CLEAR, BS_IDLE, BS_MODIFY
	} back_state_t;

	typedef struct packed {
		logic                     query;
		logic                     last;
		logic [MAX_ADDR_BITS-1:0] idx;
	} probe_t;

endpackage

@@ rtl/cbf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_ram - single-port RAM
// One address per cycle, write or read, registered read data.
// ----------------------------------------------------------------------------
module cbf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

@@ rtl/cbf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_queue - probe queue
// Four-entry FIFO of probe words between the hash front and the counter back.
// ----------------------------------------------------------------------------
module cbf_queue
	import cbf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  probe_t push_word,
	output logic   full,
	input  logic   pop,
	output probe_t pop_word,
	output logic   empty
);
	probe_t     buf_q [4];
	logic [2:0] wp_q, rp_q;

	assign empty    = (wp_q == rp_q);
	assign full     = (wp_q[1:0] == rp_q[1:0]) && (wp_q[2] != rp_q[2]);
	assign pop_word = buf_q[rp_q[1:0]];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			buf_q[wp_q[1:0]] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= wp_q + 3'd1;
			end
			if (pop && !empty) begin
				rp_q <= rp_q + 3'd1;
			end
		end
	end
endmodule

@@ rtl/cbf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_front - command intake and probe hashing
// Murmur3 x64 low word per probe on a shared 32x32 multiplier, 3 passes a
// 64-bit product. Emits one probe word per probe into the queue.
// ----------------------------------------------------------------------------
module cbf_front
	import cbf_pkg::*;
#(
	parameter int ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        action,
	input  logic [63:0] key,
	input  logic [4:0]  probe_count,
	input  logic [4:0]  table_addr_bits,
	input  logic        hold,
	output logic        busy,
	output logic        push,
	output probe_t      push_word,
	input  logic        full
);
	front_state_t state_q, state_d;
	logic [1:0]           ph_q;
	logic [63:0]          acc_q, k1_q, ha_q, hb_q;
	logic                 act_q;
	logic [4:0]           n_q;
	logic [3:0]           p_q;
	logic [SEED_W-1:0]    seed_q;
	logic [ADDR_BITS-1:0] mask_q, mask_d;
	logic [4:0]           bits_eff, n_eff;
	logic [63:0]          opa, opb, prod, mres, h1, h2, h1n, h2n, hsum;
	logic [31:0]          mx, my;
	logic                 accept, is_mul, last;

	assign accept = (state_q == FS_IDLE) && start && !hold;
	assign busy   = (state_q != FS_IDLE) || hold;

	// effective settings, clamped
	always_comb begin
		n_eff    = (probe_count == 5'd0) ? 5'd1 :
		           (probe_count > 5'(MAX_PROBES)) ? 5'(MAX_PROBES) : probe_count;
		bits_eff = (table_addr_bits == 5'd0) ? 5'd1 :
		           (table_addr_bits > 5'(ADDR_BITS)) ? 5'(ADDR_BITS) : table_addr_bits;
		for (int j = 0; j < ADDR_BITS; j++) begin
			mask_d[j] = (5'(j) < bits_eff);
		end
	end

	// shared multiplier: lo*lo, lo*hi, hi*lo
	always_comb begin
		case (state_q)
			FS_K1A: begin opa = k1_q; opb = MUL_C1; end
			FS_K1B: begin opa = k1_q; opb = MUL_C2; end
			FS_HA1: begin opa = ha_q; opb = FMIX_C1; end
			FS_HA2: begin opa = ha_q; opb = FMIX_C2; end
			FS_HB1: begin opa = hb_q; opb = FMIX_C1; end
			FS_HB2: begin opa = hb_q; opb = FMIX_C2; end
			default: begin opa = k1_q; opb = MUL_C1; end
		endcase
		mx   = (ph_q == 2'd2) ? opa[63:32] : opa[31:0];
		my   = (ph_q == 2'd1) ? opb[63:32] : opb[31:0];
		prod = mx * my;
		mres = acc_q + {prod[31:0], 32'b0};
	end

	assign is_mul = (state_q == FS_K1A) || (state_q == FS_K1B) || (state_q == FS_HA1) ||
	                (state_q == FS_HA2) || (state_q == FS_HB1) || (state_q == FS_HB2);

	always_comb begin
		h1   = {{(64-SEED_W){1'b0}}, seed_q} ^ k1_q ^ KEY_LEN;
		h2   = {{(64-SEED_W){1'b0}}, seed_q} ^ KEY_LEN;
		h1n  = h1 + h2;
		h2n  = h2 + h1n;
		hsum = ha_q + hb_q;
		last = ({1'b0, p_q} == (n_q - 5'd1));
	end

	assign push            = (state_q == FS_PUSH);
	assign push_word.query = act_q;
	assign push_word.last  = last;
	assign push_word.idx   = MAX_ADDR_BITS'(hsum[ADDR_BITS-1:0] & mask_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_IDLE: if (accept) state_d = FS_K1A;
			FS_K1A:  if (ph_q == 2'd2) state_d = FS_K1B;
			FS_K1B:  if (ph_q == 2'd2) state_d = FS_PREP;
			FS_PREP: state_d = FS_HA1;
			FS_HA1:  if (ph_q == 2'd2) state_d = FS_HA2;
			FS_HA2:  if (ph_q == 2'd2) state_d = FS_HB1;
			FS_HB1:  if (ph_q == 2'd2) state_d = FS_HB2;
			FS_HB2:  if (ph_q == 2'd2) state_d = FS_PUSH;
			FS_PUSH: if (!full) state_d = last ? FS_IDLE : FS_PREP;
			default: state_d = FS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			ph_q    <= '0;
		end else begin
			state_q <= state_d;
			ph_q    <= (is_mul && ph_q != 2'd2) ? ph_q + 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			k1_q   <= key;
			act_q  <= action;
			n_q    <= n_eff;
			mask_q <= mask_d;
			p_q    <= '0;
			seed_q <= '0;
		end
		if (is_mul) begin
			if (ph_q == 2'd0) acc_q <= prod;
			else if (ph_q == 2'd1) acc_q <= mres;
		end
		if (is_mul && ph_q == 2'd2) begin
			case (state_q)
				FS_K1A:          k1_q <= {mres[32:0], mres[63:33]};
				FS_K1B:          k1_q <= mres;
				FS_HA1, FS_HA2:  ha_q <= mres ^ (mres >> 33);
				default:         hb_q <= mres ^ (mres >> 33);
			endcase
		end
		if (state_q == FS_PREP) begin
			ha_q <= h1n ^ (h1n >> 33);
			hb_q <= h2n ^ (h2n >> 33);
		end
		if (state_q == FS_PUSH && !full) begin
			p_q    <= p_q + 4'd1;
			seed_q <= seed_q + SEED_STEP;
		end
	end
endmodule

@@ rtl/cbf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_back - counter store and probe execution
// Clears the store after reset, then runs one read-modify-write or min
// step per probe word.
// ----------------------------------------------------------------------------
module cbf_back
	import cbf_pkg::*;
#(
	parameter int ADDR_BITS     = 16,
	parameter int COUNTER_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  probe_t      pop_word,
	input  logic        empty,
	output logic        pop,
	output logic        clearing,
	output logic        done,
	output logic [15:0] count
);
	localparam int DEPTH = 1 << ADDR_BITS;
	localparam int OW    = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;

	back_state_t              state_q;
	probe_t                   cur_q;
	logic [ADDR_BITS:0]       clr_q;
	logic [COUNTER_WIDTH-1:0] min_q, mnew, rdata, wdata;
	logic [ADDR_BITS-1:0]     addr;
	logic                     we;
	logic [OW-1:0]            mext;

	assign clearing = (state_q == BS_CLEAR);
	assign pop      = (state_q == BS_IDLE) && !empty;

	always_comb begin
		we    = 1'b0;
		addr  = pop_word.idx[ADDR_BITS-1:0];
		wdata = '0;
		case (state_q)
			BS_CLEAR: begin
				we   = 1'b1;
				addr = clr_q[ADDR_BITS-1:0];
			end
			BS_MODIFY: begin
				addr  = cur_q.idx[ADDR_BITS-1:0];
				we    = !cur_q.query;
				wdata = (rdata == '1) ? rdata : rdata + COUNTER_WIDTH'(1);
			end
			default: ;
		endcase
		mnew = (rdata < min_q) ? rdata : min_q;
		mext = OW'(mnew);
	end

	cbf_ram #(.WIDTH(COUNTER_WIDTH), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_CLEAR;
			clr_q   <= '0;
			min_q   <= '1;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				BS_CLEAR: begin
					clr_q <= clr_q + (ADDR_BITS+1)'(1);
					if (clr_q == (ADDR_BITS+1)'(DEPTH - 1)) state_q <= BS_IDLE;
				end
				BS_IDLE: if (!empty) state_q <= BS_MODIFY;
				BS_MODIFY: begin
					state_q <= BS_IDLE;
					if (cur_q.query) begin
						if (cur_q.last) begin
							done  <= 1'b1;
							min_q <= '1;
						end else begin
							min_q <= mnew;
						end
					end
				end
				default: state_q <= BS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= pop_word;
		if (state_q == BS_MODIFY && cur_q.query && cur_q.last) begin
			count <= (mext > OW'(16'hffff)) ? 16'hffff : mext[15:0];
		end
	end
endmodule

@@ rtl/counting_bloom_filter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_bloom_filter_unit - counting Bloom filter, Murmur3 x64 probing
// Add increments the probed counters (saturating); query returns their min.
// ----------------------------------------------------------------------------
//  channel  | signals                               | handshake
//  ---------+---------------------------------------+---------------------------
//  command  | start, busy, action, key[63:0]        | word taken on start & !busy
//  result   | done, count[15:0]                     | one-cycle strobe, no stall
//  config   | psel penable pwrite paddr pwdata ...  | APB, pready always high
//
// Front: key setup, then four 64-bit products per probe, three passes each on
// one 32x32 multiplier. Back: one step per probe on the single-port counter
// RAM. busy is high while the front hashes a word. After reset the counter RAM
// is swept to zero with busy high. The result side cannot stall; a four-word
// probe queue decouples the halves.
// ----------------------------------------------------------------------------
module counting_bloom_filter_unit
	import cbf_pkg::*;
#(
	parameter int ADDR_BITS     = 16,
	parameter int COUNTER_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [63:0] key,
	output logic        done,
	output logic [15:0] count
);
	logic [4:0] probe_count_q, table_bits_q;
	logic       cfg_wr, clearing, push, pop, full, empty;
	probe_t     push_word, pop_word;

	// register file: word 0 probe count, word 1 table address bits
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_TABLE_BITS) ? {27'b0, table_bits_q}
	                                             : {27'b0, probe_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_count_q <= 5'd4;
			table_bits_q  <= 5'd16;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_PROBE_COUNT) probe_count_q <= pwdata[4:0];
			else                             table_bits_q  <= pwdata[4:0];
		end
	end

	cbf_front #(.ADDR_BITS(ADDR_BITS)) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.action          (action),
		.key             (key),
		.probe_count     (probe_count_q),
		.table_addr_bits (table_bits_q),
		.hold            (clearing),
		.busy            (busy),
		.push            (push),
		.push_word       (push_word),
		.full            (full)
	);

	cbf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (full),
		.pop       (pop),
		.pop_word  (pop_word),
		.empty     (empty)
	);

	cbf_back #(.ADDR_BITS(ADDR_BITS), .COUNTER_WIDTH(COUNTER_WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_word (pop_word),
		.empty    (empty),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.count    (count)
	);

	// no command is taken while the store is being swept
	a_busy_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> busy) else $error("command window open during clear");

	// no probe is executed during the sweep
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pop) else $error("probe popped during clear");

	// a result follows a step of the back end, never the sweep
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(clearing)) else $error("result during clear");
endmodule
